// ----- rtl/erte_pkg.sv -----
`timescale 1ns / 1ps
package erte_pkg;

	localparam int MAX_ENTRIES      = 64;
	localparam int CODE_UNIT_BYTES  = 2;
	localparam int VALUE_BITS       = 24;

	localparam int GROUP_BITS       = 6;
	localparam int VALUES_PER_ENTRY = 4;
	localparam int PAYLOAD_MSB      = GROUP_BITS - 1;
	localparam int CONT_BIT         = 6;

	localparam int IDX_W    = $clog2(MAX_ENTRIES);
	localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W    = $clog2(VALUES_PER_ENTRY);

	localparam int FUNC_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int QUERY_W  = 26;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int START_W  = 25;
	localparam int END_W    = 26;
	localparam int TARGET_W = 25;
	localparam int DEPTH_W  = 23;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BYTE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TRUNC = 2'd2;

	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic [START_W-1:0]  start_byte;
		logic [END_W-1:0]    end_byte;
		logic [TARGET_W-1:0] target_byte;
		logic [DEPTH_W-1:0]  stack_depth;
		logic                push_lasti;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic take_byte;
		logic scan_first;
		logic scan_next;
		logic emit_hit;
		logic emit_miss;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic hit;
		logic last;
	} dp_status_t;

endpackage

// ----- rtl/exception_range_table_engine_core.sv -----
`timescale 1ns / 1ps
// Clear and table byte transfers do not raise busy; a byte that completes an entry strobes done next cycle.
// A lookup with an empty table answers in the next cycle without raising busy.
// A lookup raises busy and scans the stored entries in order until it matches entry i or misses after all N.
// The lookup rate is set by the single registered read port of the entry memory, one entry a cycle.
// Asynchronous active-low reset clears the decoder, entry count, controller and done strobe.
// The entry memory is not cleared; the receiver cannot stall, so done is a one-cycle strobe.
module exception_range_table_engine_core
	import erte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [BYTE_W-1:0]   table_byte,
	input  logic [QUERY_W-1:0]  query_offset,
	output logic                done,
	output logic                answer_kind,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [INDEX_W-1:0]  entry_index,
	output logic [START_W-1:0]  start_byte,
	output logic [END_W-1:0]    end_byte,
	output logic [TARGET_W-1:0] target_byte,
	output logic [DEPTH_W-1:0]  stack_depth,
	output logic                push_lasti
);

	// The controller only sequences: it turns each accepted transfer into a
	// datapath command and, during a lookup, steps the scan one stored entry
	// per cycle until the datapath reports a hit or the last entry.
	cmd_t       cmd;
	dp_status_t dp_stat;

	erte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.dp_stat (dp_stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// The datapath holds the varint decoder, the entry memory with its
	// registered read port, the scan index and the result registers.
	erte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.table_byte   (table_byte),
		.query_offset (query_offset),
		.dp_stat      (dp_stat),
		.done         (done),
		.answer_kind  (answer_kind),
		.status       (status),
		.found        (found),
		.entry_index  (entry_index),
		.start_byte   (start_byte),
		.end_byte     (end_byte),
		.target_byte  (target_byte),
		.stack_depth  (stack_depth),
		.push_lasti   (push_lasti)
	);

`ifndef ASSERT_OFF
	// Only an accepted lookup may make the block busy.
	a_busy_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && ($past(func) == FUNC_LOOKUP)))
		else $error("busy rose without a lookup transfer");

	// Every result leaves the block idle, ready for the next transfer.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	// A decoded entry always reports found.
	a_entry_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (answer_kind == KIND_ENTRY)) |-> found)
		else $error("decoded entry without found");

	// A missed lookup carries zero fields and status ok.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (answer_kind == KIND_LOOKUP) && !found) |->
		((entry_index == '0) && (start_byte == '0) && (end_byte == '0) &&
		(status == STAT_OK)))
		else $error("missed lookup with nonzero fields");
`endif

endmodule

// ----- rtl/erte_ctrl.sv -----
`timescale 1ns / 1ps
module erte_ctrl
	import erte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  dp_status_t        dp_stat,
	output cmd_t              cmd,
	output logic              busy
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_CLEAR) begin
						cmd.clear = 1'b1;
					end else if (func == FUNC_BYTE) begin
						cmd.take_byte = 1'b1;
					end else if (func == FUNC_LOOKUP) begin
						if (dp_stat.count_zero) begin
							cmd.emit_miss = 1'b1;
						end else begin
							cmd.scan_first = 1'b1;
							state_d        = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (dp_stat.hit) begin
					cmd.emit_hit = 1'b1;
					state_d      = ST_IDLE;
				end else if (dp_stat.last) begin
					cmd.emit_miss = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/erte_dp.sv -----
`timescale 1ns / 1ps
module erte_dp
	import erte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [BYTE_W-1:0]   table_byte,
	input  logic [QUERY_W-1:0]  query_offset,
	output dp_status_t          dp_stat,
	output logic                done,
	output logic                answer_kind,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [INDEX_W-1:0]  entry_index,
	output logic [START_W-1:0]  start_byte,
	output logic [END_W-1:0]    end_byte,
	output logic [TARGET_W-1:0] target_byte,
	output logic [DEPTH_W-1:0]  stack_depth,
	output logic                push_lasti
);

	// Decoder state.
	logic [VALUE_BITS-1:0] acc_q;
	logic                  too_wide_q;
	logic [POS_W-1:0]      pos_q;
	logic [VALUE_BITS-1:0] earlier_q [VALUES_PER_ENTRY-1];
	logic [COUNT_W-1:0]    count_q;

	// Lookup state.
	logic [QUERY_W-1:0]    query_q;
	logic [IDX_W-1:0]      idx_q;
	entry_t                rd_q;

	entry_t                mem [MAX_ENTRIES];

	logic                  done_q;
	logic                  kind_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [INDEX_W-1:0]    index_q;
	entry_t                res_q;

	logic [VALUE_BITS-1:0] acc_next;
	logic                  too_wide_next;
	logic                  value_end;
	logic                  entry_end;
	logic                  full;
	entry_t                new_entry;
	logic [STATUS_W-1:0]   new_status;
	logic                  mem_we;
	logic                  mem_re;
	logic [IDX_W-1:0]      rd_addr;

	assign too_wide_next = too_wide_q | (acc_q[VALUE_BITS-1:VALUE_BITS-GROUP_BITS] != '0);
	assign acc_next      = {acc_q[VALUE_BITS-GROUP_BITS-1:0], table_byte[PAYLOAD_MSB:0]};
	assign value_end     = ~table_byte[CONT_BIT];
	assign entry_end     = value_end && (pos_q == POS_W'(VALUES_PER_ENTRY - 1));
	assign full          = (count_q == COUNT_W'(MAX_ENTRIES));

	always_comb begin
		new_entry.start_byte  = START_W'(earlier_q[0] * CODE_UNIT_BYTES);
		new_entry.end_byte    = END_W'((END_W'(earlier_q[0]) + END_W'(earlier_q[1]))
			* CODE_UNIT_BYTES);
		new_entry.target_byte = TARGET_W'(earlier_q[2] * CODE_UNIT_BYTES);
		new_entry.stack_depth = DEPTH_W'(acc_next >> 1);
		new_entry.push_lasti  = acc_next[0];
		priority if (full) begin
			new_status = STAT_FULL;
		end else if (too_wide_next) begin
			new_status = STAT_TRUNC;
		end else begin
			new_status = STAT_OK;
		end
	end

	assign mem_we  = cmd.take_byte && entry_end && !full;
	assign mem_re  = cmd.scan_first || cmd.scan_next;
	assign rd_addr = cmd.scan_first ? '0 : IDX_W'(idx_q + 1'b1);

	assign dp_stat.count_zero = (count_q == '0);
	assign dp_stat.hit  = ({1'b0, rd_q.start_byte} <= query_q) && (query_q < rd_q.end_byte);
	assign dp_stat.last = ((COUNT_W'(idx_q) + 1'b1) == count_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IDX_W'(count_q)] <= new_entry;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			too_wide_q <= 1'b0;
			pos_q      <= '0;
			count_q    <= '0;
		end else if (cmd.clear) begin
			acc_q      <= '0;
			too_wide_q <= 1'b0;
			pos_q      <= '0;
			count_q    <= '0;
		end else if (cmd.take_byte) begin
			if (!value_end) begin
				acc_q      <= acc_next;
				too_wide_q <= too_wide_next;
			end else if (!entry_end) begin
				acc_q      <= '0;
				too_wide_q <= too_wide_next;
				pos_q      <= pos_q + 1'b1;
			end else begin
				acc_q      <= '0;
				too_wide_q <= 1'b0;
				pos_q      <= '0;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && value_end && !entry_end) begin
			earlier_q[pos_q] <= acc_next;
		end
		if (cmd.scan_first) begin
			query_q <= query_offset;
			idx_q   <= '0;
		end else if (cmd.scan_next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.take_byte && entry_end) || cmd.emit_hit || cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && entry_end) begin
			kind_q   <= KIND_ENTRY;
			status_q <= new_status;
			found_q  <= 1'b1;
			index_q  <= full ? '0 : INDEX_W'(count_q);
			res_q    <= new_entry;
		end else if (cmd.emit_hit) begin
			kind_q   <= KIND_LOOKUP;
			status_q <= STAT_OK;
			found_q  <= 1'b1;
			index_q  <= INDEX_W'(idx_q);
			res_q    <= rd_q;
		end else if (cmd.emit_miss) begin
			kind_q   <= KIND_LOOKUP;
			status_q <= STAT_OK;
			found_q  <= 1'b0;
			index_q  <= '0;
			res_q    <= '0;
		end
	end

	assign done        = done_q;
	assign answer_kind = kind_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_index = index_q;
	assign start_byte  = res_q.start_byte;
	assign end_byte    = res_q.end_byte;
	assign target_byte = res_q.target_byte;
	assign stack_depth = res_q.stack_depth;
	assign push_lasti  = res_q.push_lasti;

endmodule

// ----- dv/exception_range_table_engine_core_test.sv -----
`timescale 1ns / 1ps
// Stimulus is built up front as a queue of table operations. A driver presents the oldest
// one at each falling edge, and a monitor at the rising edge checks results, pops accepted
// operations and runs them through the table predictor below.
module exception_range_table_engine_core_test;
	import erte_pkg::*;

	// The block ignores the fourth function code, and so does the predictor.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int ITEM_TARGET  = 800;
	localparam int GAP_PERCENT  = 29;
	localparam int STEADY_FIRST = 350;
	localparam int STEADY_LAST  = 500;
	localparam int FILL_ENTRIES = MAX_ENTRIES + 6;
	localparam int HINT_DEPTH   = 16;
	// A lookup scans at most MAX_ENTRIES entries, one a cycle, so the drain covers any tail.
	localparam int DRAIN_CYCLES = 80;
	// Nothing is accepted for at most a lookup scan plus a random gap; this is far beyond both.
	localparam int STALL_LIMIT  = 4000;
	localparam longint unsigned QUERY_MASK = (64'd1 << QUERY_W) - 1;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [BYTE_W-1:0]  tbyte;
		logic [QUERY_W-1:0] qoff;
	} table_op_t;

	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [INDEX_W-1:0]  idx;
		logic [START_W-1:0]  start_b;
		logic [END_W-1:0]    end_b;
		logic [TARGET_W-1:0] target_b;
		logic [DEPTH_W-1:0]  depth;
		logic                lasti;
	} handler_answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [FUNC_W-1:0]   func = FUNC_CLEAR;
	logic [BYTE_W-1:0]   table_byte = '0;
	logic [QUERY_W-1:0]  query_offset = '0;
	logic                busy;
	logic                done;
	logic                answer_kind;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [INDEX_W-1:0]  entry_index;
	logic [START_W-1:0]  start_byte;
	logic [END_W-1:0]    end_byte;
	logic [TARGET_W-1:0] target_byte;
	logic [DEPTH_W-1:0]  stack_depth;
	logic                push_lasti;

	// Operations waiting to be sent, and answers the predictor expects, oldest first.
	table_op_t       ops_to_send[$];
	handler_answer_t answers_due[$];

	// Hints for lookups: byte ranges of recently sent entries.
	longint unsigned hint_lo[$];
	longint unsigned hint_hi[$];

	int item_total = 0;
	int took_count = 0;
	int fail_count = 0;
	int stall_cycles = 0;
	logic took_last = 1'b0;

	table_op_t       seen_op;
	handler_answer_t due;
	handler_answer_t got;

	// Predictor state: the stored ranges and the value decoder.
	logic [START_W-1:0]    tbl_start  [MAX_ENTRIES];
	logic [END_W-1:0]      tbl_end    [MAX_ENTRIES];
	logic [TARGET_W-1:0]   tbl_target [MAX_ENTRIES];
	logic [DEPTH_W-1:0]    tbl_depth  [MAX_ENTRIES];
	logic                  tbl_lasti  [MAX_ENTRIES];
	logic [COUNT_W-1:0]    tbl_count = '0;
	logic [VALUE_BITS-1:0] dec_acc = '0;
	logic                  dec_wide = 1'b0;
	logic [POS_W-1:0]      dec_pos = '0;
	logic [VALUE_BITS-1:0] dec_prior [VALUES_PER_ENTRY-1];

	exception_range_table_engine_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.table_byte   (table_byte),
		.query_offset (query_offset),
		.done         (done),
		.answer_kind  (answer_kind),
		.status       (status),
		.found        (found),
		.entry_index  (entry_index),
		.start_byte   (start_byte),
		.end_byte     (end_byte),
		.target_byte  (target_byte),
		.stack_depth  (stack_depth),
		.push_lasti   (push_lasti)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one accepted operation to the predicted table and queues the answer it causes.
	// A byte only produces an answer when it closes the fourth value of an entry; a clear and
	// the unused code produce nothing, and a lookup always answers.
	task automatic apply_table_op(table_op_t op);
		handler_answer_t a;
		longint unsigned v;
		longint unsigned s;
		longint unsigned e;
		longint unsigned t;
		logic hit;
		a = '0;
		hit = 1'b0;
		case (op.func)
		FUNC_CLEAR: begin
			tbl_count = '0;
			dec_acc = '0;
			dec_wide = 1'b0;
			dec_pos = '0;
		end
		FUNC_BYTE: begin
			// Any bit that is about to be shifted out of the value width marks truncation.
			if ((dec_acc >> (VALUE_BITS - GROUP_BITS)) != 0)
				dec_wide = 1'b1;
			dec_acc = VALUE_BITS'({dec_acc, op.tbyte[PAYLOAD_MSB:0]});
			if (!op.tbyte[CONT_BIT]) begin
				v = 64'(dec_acc);
				dec_acc = '0;
				if (dec_pos < VALUES_PER_ENTRY - 1) begin
					dec_prior[dec_pos] = VALUE_BITS'(v);
					dec_pos = dec_pos + 1'b1;
				end else begin
					s = dec_prior[0] * CODE_UNIT_BYTES;
					e = (dec_prior[0] + dec_prior[1]) * CODE_UNIT_BYTES;
					t = dec_prior[2] * CODE_UNIT_BYTES;
					a.kind = KIND_ENTRY;
					a.found = 1'b1;
					a.status = dec_wide ? STAT_TRUNC : STAT_OK;
					a.start_b = s[START_W-1:0];
					a.end_b = e[END_W-1:0];
					a.target_b = t[TARGET_W-1:0];
					a.depth = DEPTH_W'(v >> 1);
					a.lasti = v[0];
					// A full table drops the entry; that status wins over truncation.
					if (tbl_count >= MAX_ENTRIES) begin
						a.status = STAT_FULL;
					end else begin
						a.idx = INDEX_W'(tbl_count);
						tbl_start[IDX_W'(tbl_count)] = a.start_b;
						tbl_end[IDX_W'(tbl_count)] = a.end_b;
						tbl_target[IDX_W'(tbl_count)] = a.target_b;
						tbl_depth[IDX_W'(tbl_count)] = a.depth;
						tbl_lasti[IDX_W'(tbl_count)] = a.lasti;
						tbl_count = tbl_count + 1'b1;
					end
					dec_wide = 1'b0;
					dec_pos = '0;
					answers_due.push_back(a);
				end
			end
		end
		FUNC_LOOKUP: begin
			// The first stored range that holds the offset wins; a miss is all zeros.
			a.kind = KIND_LOOKUP;
			a.status = STAT_OK;
			for (int i = 0; i < tbl_count; i++) begin
				if (!hit && op.qoff >= tbl_start[i] && op.qoff < tbl_end[i]) begin
					hit = 1'b1;
					a.found = 1'b1;
					a.idx = INDEX_W'(i);
					a.start_b = tbl_start[i];
					a.end_b = tbl_end[i];
					a.target_b = tbl_target[i];
					a.depth = tbl_depth[i];
					a.lasti = tbl_lasti[i];
				end
			end
			answers_due.push_back(a);
		end
		default: begin
		end
		endcase
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
			fail_count++;
		end
	endtask

	task automatic send_op(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b, logic [QUERY_W-1:0] q);
		table_op_t op;
		op.func = f;
		op.tbyte = b;
		op.qoff = q;
		ops_to_send.push_back(op);
		if (f != FUNC_UNUSED)
			item_total++;
	endtask

	task automatic send_clear();
		send_op(FUNC_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
		hint_lo.delete();
		hint_hi.delete();
	endtask

	// Lookups mostly aim inside, at the start or at the exclusive end of a recent range.
	task automatic send_lookup();
		longint unsigned q;
		int k;
		int r;
		r = $urandom_range(99);
		if (hint_lo.size() != 0 && r < 70) begin
			k = $urandom_range(hint_lo.size() - 1);
			if (r < 40 && hint_hi[k] > hint_lo[k])
				q = hint_lo[k] + $urandom_range(int'(hint_hi[k] - hint_lo[k] - 1));
			else if (r < 55)
				q = hint_hi[k];
			else
				q = hint_lo[k];
		end else if (r < 85) begin
			q = 64'($urandom_range(600));
		end else begin
			q = 64'($urandom);
		end
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), QUERY_W'(q & QUERY_MASK));
	endtask

	// Encodes one value most significant group first, sometimes with a leading zero group,
	// and now and then slips a lookup in between the bytes of the value.
	task automatic send_value(longint unsigned v);
		logic [BYTE_W-1:0] b;
		int groups;
		groups = 1;
		while (groups < 5 && (v >> (GROUP_BITS * groups)) != 0)
			groups++;
		if ($urandom_range(99) < 15)
			groups++;
		for (int g = groups - 1; g >= 0; g--) begin
			b = BYTE_W'($urandom);
			b[PAYLOAD_MSB:0] = GROUP_BITS'(v >> (GROUP_BITS * g));
			b[CONT_BIT] = (g != 0);
			send_op(FUNC_BYTE, b, QUERY_W'($urandom));
			if (g != 0 && $urandom_range(99) < 4)
				send_lookup();
		end
	endtask

	task automatic send_entry(longint unsigned s, longint unsigned sz, longint unsigned t,
			longint unsigned dl);
		send_value(s);
		send_value(sz);
		send_value(t);
		send_value(dl);
		hint_lo.push_back((s * CODE_UNIT_BYTES) & QUERY_MASK);
		hint_hi.push_back(((s + sz) * CODE_UNIT_BYTES) & QUERY_MASK);
		if (hint_lo.size() > HINT_DEPTH) begin
			void'(hint_lo.pop_front());
			void'(hint_hi.pop_front());
		end
	endtask

	// Mostly small values so that ranges overlap, some full width, and some too wide.
	function automatic longint unsigned pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 64'($urandom_range(200));
		if (r < 92)
			return 64'($urandom & 32'h00FF_FFFF);
		return (longint'($urandom_range(63, 1)) << VALUE_BITS) | ($urandom & 32'h00FF_FFFF);
	endfunction

	// The driver presents the oldest pending operation and holds it until it is taken.
	// Gaps are random except for a steady stretch in the middle of the run.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took_last) begin
			if (ops_to_send.size() != 0 &&
					((took_count >= STEADY_FIRST && took_count < STEADY_LAST) ||
					$urandom_range(99) >= GAP_PERCENT)) begin
				start <= 1'b1;
				func <= ops_to_send[0].func;
				table_byte <= ops_to_send[0].tbyte;
				query_offset <= ops_to_send[0].qoff;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// The monitor checks a result strobe against the oldest expected answer before it feeds
	// the transfer accepted at the same edge to the predictor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result strobe with no answer expected");
					fail_count++;
				end else begin
					due = answers_due.pop_front();
					got = {answer_kind, status, found, entry_index, start_byte, end_byte,
						target_byte, stack_depth, push_lasti};
					check_field("answer_kind", due.kind, got.kind);
					check_field("status", due.status, got.status);
					check_field("found", due.found, got.found);
					check_field("entry_index", due.idx, got.idx);
					check_field("start_byte", due.start_b, got.start_b);
					check_field("end_byte", due.end_b, got.end_b);
					check_field("target_byte", due.target_b, got.target_b);
					check_field("stack_depth", due.depth, got.depth);
					check_field("push_lasti", due.lasti, got.lasti);
				end
			end
			if (start && !busy) begin
				seen_op.func = func;
				seen_op.tbyte = table_byte;
				seen_op.qoff = query_offset;
				void'(ops_to_send.pop_front());
				took_count++;
				apply_table_op(seen_op);
			end
			took_last <= start && !busy;
		end
	end

	// The watchdog ends a run in which neither a transfer nor a result happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("exception_range_table_engine_core_test: FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int pick;

		// Directed part: an empty lookup, an all-zero entry with an empty range, an entry at
		// the widest values, hits and misses at the edges, the unused code and a clear.
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), '0);
		send_entry(0, 0, 0, 0);
		send_entry(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), 26'h1FF_FFFE);
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), 26'h3FF_FFFB);
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), 26'h3FF_FFFF);
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), '0);
		send_op(FUNC_UNUSED, 8'hFF, '1);
		send_clear();
		send_op(FUNC_LOOKUP, BYTE_W'($urandom), '0);

		// Fill the table past its capacity without a clear, so that the last entries are
		// dropped; one of them also carries a value that is too wide.
		send_clear();
		for (int n = 0; n < FILL_ENTRIES; n++) begin
			if (n == MAX_ENTRIES + 2)
				send_entry($urandom_range(63), $urandom_range(63), 30'h3FFF_FFFF,
					$urandom_range(63));
			else
				send_entry($urandom_range(63), $urandom_range(63), $urandom_range(63),
					$urandom_range(63));
			if ($urandom_range(99) < 12)
				send_lookup();
		end

		// Random phases: mostly whole entries and lookups, with some noise and some entries
		// cut short, followed by a clear or left to shift the value alignment.
		while (item_total < ITEM_TARGET) begin
			if ($urandom_range(99) < 60)
				send_clear();
			repeat ($urandom_range(8, 2)) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					send_entry(pick_value(), pick_value(), pick_value(), pick_value());
				end else if (pick < 85) begin
					send_lookup();
				end else if (pick < 93) begin
					send_op(FUNC_W'($urandom_range(3)), BYTE_W'($urandom),
						QUERY_W'($urandom));
				end else begin
					send_value(pick_value());
					if ($urandom_range(1))
						send_clear();
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (ops_to_send.size() != 0 || start || answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("exception_range_table_engine_core_test: PASS");
		else
			$display("exception_range_table_engine_core_test: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/erte_pkg.sv
rtl/erte_ctrl.sv
rtl/erte_dp.sv
rtl/exception_range_table_engine_core.sv
dv/exception_range_table_engine_core_test.sv
